/* hw/rtl/magnetometer_hard_iron_calibration_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros of the hard-iron calibration checker.
// ---------------------------------------------------------------------------
`ifndef MAGNETOMETER_HARD_IRON_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_HARD_IRON_CALIBRATION_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define HIC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk and disabled during rst.
`define HIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/hic_pkg.sv */
// ---------------------------------------------------------------------------
// hic_pkg
// Types, constants and helpers of the hard-iron calibration block.
// ---------------------------------------------------------------------------
`default_nettype none

package hic_pkg;

  localparam int unsigned AXES = 3;
  localparam int unsigned DIV_BITS = 24;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

  localparam logic [15:0] CAL_SAMPLES_RESET = 16'd2000;
  localparam logic [14:0] RANGE_LIMIT_RESET = 15'd400;
  localparam logic signed [15:0] AXIS_MAX_RESET = -16'sd100;
  localparam logic signed [15:0] AXIS_MIN_RESET = 16'sd100;
  localparam logic [15:0] GAIN_ONE = 16'd256;
  localparam logic [15:0] GAIN_SAT = 16'hFFFF;

  typedef enum logic [0:0] {
    REG_CAL_SAMPLES = 1'b0,
    REG_RANGE_LIMIT = 1'b1
  } hic_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_OFFSET,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_DIV_Z,
    ST_WAIT_Z,
    ST_EMIT
  } hic_state_t;

  typedef struct packed {
    logic in_ready;
    logic update;
    logic offset;
    logic div_start;
    logic div_sel_z;
    logic emit;
  } hic_cmd_t;

  typedef struct packed {
    logic complete;
    logic div_done;
    logic out_free;
  } hic_status_t;

  // Magnitude of a 16-bit two's complement value; -32768 maps to 32768.
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    logic [15:0] mag;
    mag = v[15] ? 16'(-v) : 16'(v);
    return mag;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hic_sample_if.sv */
// ---------------------------------------------------------------------------
// hic_sample_if
// Raw magnetometer sample channel: valid/ready plus three words and request.
// ---------------------------------------------------------------------------
`default_nettype none

interface hic_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] word_first;
  logic [15:0] word_second;
  logic [15:0] word_third;
  logic        calibrate_request;

  modport source (output valid, word_first, word_second, word_third, calibrate_request,
                  input ready);
  modport sink (input valid, word_first, word_second, word_third, calibrate_request,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/hic_result_if.sv */
// ---------------------------------------------------------------------------
// hic_result_if
// Corrected sample channel: valid/ready plus corrections, offsets and gains.
// ---------------------------------------------------------------------------
`default_nettype none

interface hic_result_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] corrected_x;
  logic signed [16:0] corrected_y;
  logic signed [16:0] corrected_z;
  logic signed [15:0] offset_x_out;
  logic signed [15:0] offset_y_out;
  logic signed [15:0] offset_z_out;
  logic [15:0]        gain_y_out;
  logic [15:0]        gain_z_out;
  logic               calibration_done;
  logic               calibrating_out;

  modport source (output valid, corrected_x, corrected_y, corrected_z, offset_x_out,
                  offset_y_out, offset_z_out, gain_y_out, gain_z_out,
                  calibration_done, calibrating_out,
                  input ready);
  modport sink (input valid, corrected_x, corrected_y, corrected_z, offset_x_out,
                offset_y_out, offset_z_out, gain_y_out, gain_z_out,
                calibration_done, calibrating_out,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/hic_divider.sv */
// ---------------------------------------------------------------------------
// hic_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module hic_divider
  import hic_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DIV_BITS-1:0] num,
  input  wire logic [16:0]         den,
  output logic                     done,
  output logic [DIV_BITS-1:0]      quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [16:0]          rem;
  logic [DIV_BITS-1:0]  quo;
  logic [17:0]          trial;
  logic                 fits;

  assign trial = {rem, quo[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the remainder stays below the divisor, so 17 bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? 17'(trial - {1'b0, den}) : trial[16:0];
      quo <= {quo[DIV_BITS-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

/* hw/rtl/hic_datapath.sv */
// ---------------------------------------------------------------------------
// hic_datapath
// Axis remap, offset correction, min/max tracking, offsets, gains, output.
// ---------------------------------------------------------------------------
`default_nettype none

module hic_datapath
  import hic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [0:0]  write_index,
  input  wire logic [15:0] write_data,
  input  wire hic_cmd_t    cmd,
  output hic_status_t      status,
  hic_sample_if.sink       sample,
  hic_result_if.source     result
);

  // configuration
  logic [15:0] cal_samples;
  logic [14:0] range_limit;

  // captured sample
  logic signed [15:0] ax [AXES];
  logic               req;

  // calibration state
  logic signed [15:0] axis_max [AXES];
  logic signed [15:0] axis_min [AXES];
  logic signed [15:0] offset [AXES];
  logic signed [16:0] span [AXES];
  logic [15:0]        sample_count;
  logic               calibrating;
  logic [15:0]        gain_y;
  logic [15:0]        gain_z;
  logic               done_flag;
  logic signed [16:0] corr [AXES];

  // output register
  logic out_valid;

  logic                cal;
  logic                in_range;
  logic                complete;
  logic [DIV_BITS-1:0] div_num;
  logic [16:0]         div_den;
  logic                div_done;
  logic [DIV_BITS-1:0] div_q;
  logic                gain_sat;
  logic [15:0]         gain_next;

  // (max + min) / 2 truncated toward zero
  function automatic logic signed [15:0] offset_half(input logic signed [15:0] hi,
                                                    input logic signed [15:0] lo);
    logic signed [16:0] sum;
    logic signed [16:0] adj;
    sum = 17'(hi) + 17'(lo);
    adj = sum + {16'd0, sum[16]};
    return adj[16:1];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RESET;
      range_limit <= RANGE_LIMIT_RESET;
    end else if (write_enable) begin
      unique case (hic_reg_t'(write_index))
        REG_CAL_SAMPLES: cal_samples <= write_data;
        REG_RANGE_LIMIT: range_limit <= write_data[14:0];
        default: ;
      endcase
    end
  end

  // remap: x is the second word, y the first, z the negated third
  always_ff @(posedge clk) begin
    if (cmd.in_ready && sample.valid) begin
      ax[0] <= sample.word_second;
      ax[1] <= sample.word_first;
      ax[2] <= 16'(-sample.word_third);
      req   <= sample.calibrate_request;
    end
  end

  assign cal      = calibrating | req;
  assign in_range = (abs16(ax[0]) < {1'b0, range_limit})
                 && (abs16(ax[1]) < {1'b0, range_limit})
                 && (abs16(ax[2]) < {1'b0, range_limit});
  assign complete = cal && in_range && (sample_count == cal_samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        axis_max[i] <= AXIS_MAX_RESET;
        axis_min[i] <= AXIS_MIN_RESET;
        offset[i]   <= '0;
      end
      sample_count <= '0;
      calibrating  <= 1'b0;
      done_flag    <= 1'b0;
    end else begin
      if (cmd.update) begin
        if (cal && in_range) begin
          for (int i = 0; i < AXES; i++) begin
            if (ax[i] > axis_max[i]) axis_max[i] <= ax[i];
            if (ax[i] < axis_min[i]) axis_min[i] <= ax[i];
          end
        end
        if (cal) sample_count <= complete ? 16'd1 : 16'(sample_count + 1'b1);
        calibrating <= cal && !complete;
        done_flag   <= complete;
      end
      if (cmd.offset) begin
        for (int i = 0; i < AXES; i++) begin
          offset[i] <= offset_half(axis_max[i], axis_min[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int i = 0; i < AXES; i++) begin
        corr[i] <= 17'(ax[i]) - 17'(offset[i]);
      end
    end
    if (cmd.offset) begin
      for (int i = 0; i < AXES; i++) begin
        span[i] <= 17'(axis_max[i]) - 17'(axis_min[i]);
      end
    end
  end

  // gains: span_x * 256 / span_other, shared serial divider
  assign div_num = {span[0][15:0], 8'd0};
  assign div_den = cmd.div_sel_z ? span[2] : span[1];

  hic_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (div_num),
    .den      (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign gain_sat  = span[0][16] || div_den[16] || (div_den == '0)
                  || (div_q[DIV_BITS-1:16] != '0);
  assign gain_next = gain_sat ? GAIN_SAT : div_q[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_y <= GAIN_ONE;
      gain_z <= GAIN_ONE;
    end else if (div_done) begin
      if (cmd.div_sel_z) gain_z <= gain_next;
      else gain_y <= gain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.corrected_x      <= corr[0];
      result.corrected_y      <= corr[1];
      result.corrected_z      <= corr[2];
      result.offset_x_out     <= offset[0];
      result.offset_y_out     <= offset[1];
      result.offset_z_out     <= offset[2];
      result.gain_y_out       <= gain_y;
      result.gain_z_out       <= gain_z;
      result.calibration_done <= done_flag;
      result.calibrating_out  <= calibrating;
    end
  end

  assign result.valid    = out_valid;
  assign sample.ready    = cmd.in_ready;
  assign status.complete = complete;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || result.ready;

endmodule

`default_nettype wire

/* hw/rtl/hic_controller.sv */
// ---------------------------------------------------------------------------
// hic_controller
// Sequencer of the calibration datapath: update, offsets, gains, emit.
// ---------------------------------------------------------------------------
`default_nettype none

module hic_controller
  import hic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire hic_status_t status,
  output hic_cmd_t         cmd
);

  hic_state_t state;
  hic_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = status.complete ? ST_OFFSET : ST_EMIT;
      ST_OFFSET: state_next = ST_DIV_Y;
      ST_DIV_Y:  state_next = ST_WAIT_Y;
      ST_WAIT_Y: if (status.div_done) state_next = ST_DIV_Z;
      ST_DIV_Z:  state_next = ST_WAIT_Z;
      ST_WAIT_Z: if (status.div_done) state_next = ST_EMIT;
      ST_EMIT:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.in_ready = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_OFFSET: cmd.offset = 1'b1;
      ST_DIV_Y:  cmd.div_start = 1'b1;
      ST_WAIT_Y: ;
      ST_DIV_Z: begin
        cmd.div_start = 1'b1;
        cmd.div_sel_z = 1'b1;
      end
      ST_WAIT_Z: cmd.div_sel_z = 1'b1;
      ST_EMIT:   cmd.emit = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/magnetometer_hard_iron_calibration.sv */
// ---------------------------------------------------------------------------
// magnetometer_hard_iron_calibration
// Min/max hard-iron calibration of a three-axis magnetometer stream.
// ---------------------------------------------------------------------------
// Usage:
//   sample  : raw samples in (three words and a calibrate
//             request); a transaction completes when valid and ready are high.
//   result  : one transaction per sample: axes minus the offsets held before
//             the sample, offsets and Q8.8 gains after it, done and active flags.
//   write_* : configuration writes (index 0 sample count, index 1 range limit),
//             taken only while no sample is in flight: a rule on the user, not enforced by the block.
// Sequence: the result is registered in the emit state after the update state;
//   for a sample that completes a run the offset state and two 24-step passes
//   of the one shared serial divider that forms the gains come before emit.
// Flow: the controller handles one sample at a time through update and emit;
//   no new sample is accepted until the previous one has been emitted.
// Reset (rst, synchronous): registers to their defaults, min/max to +-100,
//   offsets zero, gains one, no calibration in progress, output empty.
// Stall: a finished result waits in the output register; the next sample is
//   still accepted and processed, then held until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module magnetometer_hard_iron_calibration
  import hic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        write_enable,
  input  wire logic [0:0]  write_index,
  input  wire logic [15:0] write_data,
  hic_sample_if.sink       sample,
  hic_result_if.source     result
);

  hic_cmd_t    cmd;
  hic_status_t status;

  // sequence each sample: capture, update, optional offsets and gains, emit
  hic_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // hold configuration, calibration state and the output register
  hic_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .result       (result)
  );

endmodule

`default_nettype wire

/* hw/rtl/hic_checker.sv */
// ---------------------------------------------------------------------------
// hic_checker
// Port-level assertions on the hard-iron calibration block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "magnetometer_hard_iron_calibration_macros.svh"

module hic_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [16:0] corrected_x,
  input wire logic signed [15:0] offset_x_out,
  input wire logic               calibration_done,
  input wire logic               calibrating_out
);

  `HIC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `HIC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(corrected_x) && $stable(offset_x_out), "result changed while stalled")
  `HIC_ASSERT_NEXT(a_one_at_time, in_valid && in_ready, !in_ready, "sample taken while one is in flight")
  `HIC_ASSERT_SAME(a_done_ends, out_valid && calibration_done, !calibrating_out, "run completed but still active")

endmodule

bind magnetometer_hard_iron_calibration hic_checker u_hic_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (sample.valid),
  .in_ready         (sample.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .corrected_x      (result.corrected_x),
  .offset_x_out     (result.offset_x_out),
  .calibration_done (result.calibration_done),
  .calibrating_out  (result.calibrating_out)
);

`default_nettype wire
